// File: hw/rtl/signed_text_to_integer_any_base_unit_assert.svh
// Assertion macros shared by the checker. Each expects clk and arst_n in scope.
`ifndef SIGNED_TEXT_TO_INTEGER_ANY_BASE_UNIT_ASSERT_SVH
`define SIGNED_TEXT_TO_INTEGER_ANY_BASE_UNIT_ASSERT_SVH

// same-cycle implication
`define STTI_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stti: same-cycle check failed");

// next-cycle implication
`define STTI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stti: next-cycle check failed");

`endif

// File: hw/rtl/stti_pkg.sv
package stti_pkg;

	localparam int unsigned MAX_SYMBOLS = 16;
	localparam int unsigned SYM_SLOTS   = 16;
	localparam int unsigned DIGIT_W     = $clog2(SYM_SLOTS);
	localparam int unsigned RADIX_W     = 5;
	localparam int unsigned VALUE_W     = 32;
	localparam int unsigned CFG_DATA_W  = 64;
	localparam int unsigned CFG_IDX_W   = 2;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_HIGH = 2'd2;

	localparam logic [RADIX_W-1:0]    RST_SYMBOL_COUNT  = 5'd10;
	localparam logic [CFG_DATA_W-1:0] RST_ALPHABET_LOW  = 64'h3837363534333231;
	localparam logic [CFG_DATA_W-1:0] RST_ALPHABET_HIGH = 64'h0000000000003938;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);

	typedef logic [SYM_SLOTS-1:0][7:0] symbols_t;

	typedef enum logic [2:0] {
		CLS_SPACE,
		CLS_PLUS,
		CLS_MINUS,
		CLS_DIGIT,
		CLS_OTHER
	} cls_t;

	typedef struct packed {
		logic                 start;
		cls_t                 cls;
		logic [DIGIT_W-1:0]   digit;
	} item_t;

	typedef struct packed {
		logic [RADIX_W-1:0] radix;
		symbols_t           symbols;
		logic               alph_ok;
	} cfg_t;

	function automatic logic alph_valid(input logic [RADIX_W-1:0] n, input symbols_t s);
		logic ok;
		ok = (n >= RADIX_W'(2)) && (n <= RADIX_W'(MAX_SYMBOLS)) && (n <= RADIX_W'(SYM_SLOTS));
		for (int i = 0; i < SYM_SLOTS; i++) begin
			if (RADIX_W'(i) < n) begin
				if (s[i] == CH_PLUS || s[i] == CH_MINUS || s[i] <= CH_SPACE || s[i] >= CH_DEL)
					ok = 1'b0;
				for (int j = i + 1; j < SYM_SLOTS; j++) begin
					if (RADIX_W'(j) < n && s[j] == s[i])
						ok = 1'b0;
				end
			end
		end
		return ok;
	endfunction

endpackage

// File: hw/rtl/signed_text_to_integer_any_base_unit.sv
// Signed integer parser over a configurable digit alphabet.
// Input channel (in_valid/in_stall): one text byte per beat, with string_start
// marking the first byte of a string. Output channel (out_valid/out_stall):
// one beat per parsed number, parsed_value plus alphabet_invalid.
// Configuration: cfg_wr_en with cfg_index 0 (symbol count), 1 (symbols 0-7),
// 2 (symbols 8-15); write only while no string is in flight.
// Throughput: one byte per cycle while in_stall is low. A front classifier
// matches each byte against all symbols in parallel and drops it into a
// four-entry queue; the back end retires one queued byte per cycle with one
// 32x5 multiply-add, unless a held output beat stalls it. A byte passes
// through the queue register and then the output register to out_valid.
// out_stall holds the output register; while it holds a beat, the back end
// halts, the queue fills, and in_stall rises once four bytes are waiting.
// Reset: queue emptied, parser finished (bytes ignored until a string start),
// symbol count 10 and the default alphabet loaded.
module signed_text_to_integer_any_base_unit
	import stti_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                text_byte,
	input  logic                      string_start,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VALUE_W-1:0] parsed_value,
	output logic                      alphabet_invalid,
	input  logic                      cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_wdata
);

	cfg_t  cfg;
	logic  push, q_full, pop, q_empty;
	item_t push_item, pop_item;

	stti_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr_en),
		.wr_index (cfg_index),
		.wr_data  (cfg_wdata),
		.cfg      (cfg)
	);

	stti_front u_front (
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.text_byte    (text_byte),
		.string_start (string_start),
		.cfg          (cfg),
		.push         (push),
		.push_item    (push_item),
		.q_full       (q_full)
	);

	stti_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	stti_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.item             (pop_item),
		.q_empty          (q_empty),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.parsed_value     (parsed_value),
		.alphabet_invalid (alphabet_invalid)
	);

endmodule

// File: hw/rtl/stti_cfg.sv
module stti_cfg
	import stti_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	logic [RADIX_W-1:0]    count_q;
	logic [CFG_DATA_W-1:0] alo_q;
	logic [CFG_DATA_W-1:0] ahi_q;
	logic                  ok_q;
	symbols_t              symbols;

	assign symbols = {ahi_q, alo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= RST_SYMBOL_COUNT;
			alo_q   <= RST_ALPHABET_LOW;
			ahi_q   <= RST_ALPHABET_HIGH;
			ok_q    <= alph_valid(RST_SYMBOL_COUNT, {RST_ALPHABET_HIGH, RST_ALPHABET_LOW});
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_SYMBOL_COUNT:  count_q <= wr_data[RADIX_W-1:0];
					REG_ALPHABET_LOW:  alo_q   <= wr_data;
					REG_ALPHABET_HIGH: ahi_q   <= wr_data;
					default: ;
				endcase
			end
			// recheck the alphabet every cycle from the stored registers
			ok_q <= alph_valid(count_q, symbols);
		end
	end

	assign cfg.radix   = count_q;
	assign cfg.symbols = symbols;
	assign cfg.alph_ok = ok_q;

endmodule

// File: hw/rtl/stti_front.sv
module stti_front
	import stti_pkg::*;
(
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] text_byte,
	input  logic       string_start,
	input  cfg_t       cfg,
	output logic       push,
	output item_t      push_item,
	input  logic       q_full
);

	logic               hit;
	logic [DIGIT_W-1:0] digit;

	// lowest matching symbol wins
	always_comb begin
		hit   = 1'b0;
		digit = '0;
		for (int i = SYM_SLOTS - 1; i >= 0; i--) begin
			if (RADIX_W'(i) < cfg.radix && cfg.symbols[i] == text_byte) begin
				hit   = 1'b1;
				digit = DIGIT_W'(i);
			end
		end
	end

	always_comb begin
		push_item.start = string_start;
		push_item.digit = digit;
		if ((text_byte >= CH_TAB && text_byte <= CH_CR) || text_byte == CH_SPACE)
			push_item.cls = CLS_SPACE;
		else if (text_byte == CH_PLUS)
			push_item.cls = CLS_PLUS;
		else if (text_byte == CH_MINUS)
			push_item.cls = CLS_MINUS;
		else if (hit)
			push_item.cls = CLS_DIGIT;
		else
			push_item.cls = CLS_OTHER;
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

endmodule

// File: hw/rtl/stti_fifo.sv
module stti_fifo
	import stti_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output item_t pop_item,
	output logic  empty
);

	item_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full     = count_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// File: hw/rtl/stti_back.sv
module stti_back
	import stti_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  item_t                     item,
	input  logic                      q_empty,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VALUE_W-1:0] parsed_value,
	output logic                      alphabet_invalid
);

	typedef enum logic [1:0] {
		PH_DONE,
		PH_SPACE,
		PH_SIGN,
		PH_DIGIT
	} phase_t;

	phase_t               phase_q, eff_phase, nxt_phase;
	logic                 neg_q, eff_neg, nxt_neg;
	logic [VALUE_W-1:0]   acc_q, eff_acc, nxt_acc;
	logic [VALUE_W-1:0]   prod, mac;
	logic                 emit, emit_inv;
	logic [VALUE_W-1:0]   emit_val;
	logic                 out_valid_q;
	logic [VALUE_W-1:0]   value_q;
	logic                 inv_q;

	assign pop = !q_empty && (!out_valid_q || !out_stall);

	always_comb begin
		eff_phase = item.start ? PH_SPACE : phase_q;
		eff_neg   = item.start ? 1'b0 : neg_q;
		eff_acc   = item.start ? '0 : acc_q;
		prod      = VALUE_W'(eff_acc * VALUE_W'(cfg.radix));
		mac       = prod + VALUE_W'(item.digit);
		nxt_phase = eff_phase;
		nxt_neg   = eff_neg;
		nxt_acc   = eff_acc;
		emit      = 1'b0;
		emit_inv  = 1'b0;
		emit_val  = '0;
		case (eff_phase)
			PH_DONE: ;
			default: begin
				if (!cfg.alph_ok) begin
					emit      = 1'b1;
					emit_inv  = 1'b1;
					nxt_phase = PH_DONE;
				end else if (eff_phase == PH_SPACE && item.cls == CLS_SPACE) begin
					nxt_phase = PH_SPACE;
				end else if (eff_phase != PH_DIGIT && item.cls == CLS_PLUS) begin
					nxt_phase = PH_SIGN;
				end else if (eff_phase != PH_DIGIT && item.cls == CLS_MINUS) begin
					nxt_phase = PH_SIGN;
					nxt_neg   = !eff_neg;
				end else if (item.cls == CLS_DIGIT) begin
					nxt_phase = PH_DIGIT;
					nxt_acc   = mac;
				end else begin
					// any other byte closes the number
					emit      = 1'b1;
					emit_val  = eff_neg ? (~eff_acc + 1'b1) : eff_acc;
					nxt_phase = PH_DONE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_DONE;
			neg_q       <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			value_q     <= '0;
			inv_q       <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= nxt_phase;
				neg_q   <= nxt_neg;
				acc_q   <= nxt_acc;
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
				value_q     <= emit_val;
				inv_q       <= emit_inv;
			end else if (!out_stall) begin
				// drop the beat once it has been taken
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign parsed_value     = $signed(value_q);
	assign alphabet_invalid = inv_q;

endmodule

// File: hw/rtl/stti_checker.sv
`include "signed_text_to_integer_any_base_unit_assert.svh"

module stti_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] parsed_value,
	input logic               alphabet_invalid
);

	// a held beat keeps its payload
	`STTI_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(parsed_value) && $stable(alphabet_invalid))

	// an invalid alphabet always reports zero
	`STTI_ASSERT_NOW(a_invalid_zero, out_valid && alphabet_invalid, parsed_value == 32'sd0)

	// with the output free the back end drains, so the queue cannot stay full
	`STTI_ASSERT_NEXT(a_no_stall_when_drained, !out_valid, !in_stall)

endmodule

bind signed_text_to_integer_any_base_unit stti_checker u_stti_checker (.*);
